FILE: hdl/fmrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame MAC rewrite bridge package
// Word types, frame layout constants and the MAC byte select shared by the
// bridge modules.
// ----------------------------------------------------------------------------
package fmrb_pkg;

    localparam int MAX_FRAME_BYTES = 2047;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam int MAC_LEN     = 6;
    localparam int HDR_LEN     = 14;
    localparam int IDX_W       = $clog2(HDR_LEN);
    localparam int MAC_IDX_W   = $clog2(MAC_LEN);
    localparam int SRC_POS     = MAC_LEN;
    localparam int TYPE_HI_POS = 12;
    localparam int ARP_SHA_POS = MAC_LEN + 16;
    localparam int ARP_THA_POS = HDR_LEN + 18;

    localparam logic [15:0] TYPE_ARP  = 16'h0806;
    localparam logic [15:0] TYPE_IPV6 = 16'h86DD;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_start;
        logic       frame_end;
        logic       toward_wired;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_word;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
        logic             wired;
        logic             arp;
        logic             last;
    } t_byte_req;

    // Byte k of a MAC address, byte 0 being the most significant.
    function automatic logic [7:0] mac_byte(input logic [47:0] mac,
                                            input logic [MAC_IDX_W-1:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            3'd5:    b = mac[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: hdl/frame_mac_rewrite_bridge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame MAC rewrite bridge
// Layer-2 MAC translation between a wired and a wireless port, one frame
// byte per word.
//
//   channel   handshake                 payload
//   input     i_in_valid / o_in_stall   i_in_word  (t_in_word)
//   output    o_out_valid / i_out_stall o_out_word (t_out_word)
//   config    i_cfg_we                  i_cfg_wdata (station MAC)
//
// A byte past the header is registered in the output or skid register. Header
// bytes are silent; the word that completes the header, or ends a short frame,
// starts a release of up to fourteen held words at one per cycle from the
// header store while the skid is free, and input is stalled during that
// release; IPv6 frames are dropped. Reset is synchronous and clears control
// flags. A skid register absorbs output stall; input stalls while it is full.
// ----------------------------------------------------------------------------
module frame_mac_rewrite_bridge_unit
    import fmrb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [47:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word
);

    logic [47:0] r_station_mac;
    logic [47:0] w_learned_mac;
    logic        w_acc;
    logic        w_full;
    logic        w_req_valid;
    t_byte_req   w_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_mac <= '0;
        end else if (i_cfg_we) begin
            r_station_mac <= i_cfg_wdata;
        end
    end

    assign w_acc = i_in_valid && !o_in_stall;

    fmrb_track u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (w_acc),
        .i_in_word     (i_in_word),
        .i_full        (w_full),
        .o_in_stall    (o_in_stall),
        .o_req_valid   (w_req_valid),
        .o_req         (w_req),
        .o_learned_mac (w_learned_mac)
    );

    fmrb_rewrite u_rewrite (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (w_req_valid),
        .i_req         (w_req),
        .i_station_mac (r_station_mac),
        .i_learned_mac (w_learned_mac),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_word    (o_out_word),
        .o_full        (w_full)
    );

`ifndef ASSERT_OFF
    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_valid |-> !w_full)
        else $error("word produced while the skid register is occupied");

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> o_out_valid)
        else $error("skid register occupied with an empty output register");

    a_learn_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$stable(w_learned_mac) && $past(i_rst_n)) |-> $past(w_acc))
        else $error("host MAC changed without an accepted word");
`endif

endmodule

FILE: hdl/fmrb_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame MAC rewrite bridge frame tracker
// Follows the byte position, holds the header until the type is known, learns
// the host MAC and releases held or passing bytes one per cycle unless i_full.
// ----------------------------------------------------------------------------
module fmrb_track
    import fmrb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_acc,
    input  t_in_word    i_in_word,
    input  logic        i_full,
    output logic        o_in_stall,
    output logic        o_req_valid,
    output t_byte_req   o_req,
    output logic [47:0] o_learned_mac
);

    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_drop, n_drop;
    logic                 r_arp, n_arp;
    logic [47:0]          r_learned, n_learned;
    logic                 r_drain, n_drain;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_last_idx, n_last_idx;
    logic                 r_d_wired, n_d_wired;
    logic                 r_d_arp, n_d_arp;
    logic                 r_d_end, n_d_end;
    logic [7:0]           r_hold [HDR_LEN];
    logic [7:0]           r_src [MAC_LEN];

    logic [POS_W-1:0]     pos_base;
    logic                 drop_base;
    logic                 arp_base;
    logic                 in_hdr;
    logic                 in_src;
    logic [IDX_W-1:0]     hdr_idx;
    logic [POS_W-1:0]     src_off;
    logic [MAC_IDX_W-1:0] src_idx;
    logic [15:0]          type_now;

    assign pos_base  = i_in_word.frame_start ? '0 : r_pos;
    assign drop_base = i_in_word.frame_start ? 1'b0 : r_drop;
    assign arp_base  = i_in_word.frame_start ? 1'b0 : r_arp;
    assign in_hdr    = !drop_base && (pos_base < POS_W'(HDR_LEN));
    assign hdr_idx   = pos_base[IDX_W-1:0];
    assign src_off   = pos_base - POS_W'(SRC_POS);
    assign src_idx   = src_off[MAC_IDX_W-1:0];
    assign in_src    = in_hdr && (pos_base >= POS_W'(SRC_POS))
                       && (pos_base < POS_W'(SRC_POS + MAC_LEN));
    assign type_now  = {r_hold[TYPE_HI_POS], i_in_word.frame_byte};

    assign o_in_stall    = r_drain || i_full;
    assign o_learned_mac = r_learned;

    always_comb begin
        n_pos       = r_pos;
        n_drop      = r_drop;
        n_arp       = r_arp;
        n_learned   = r_learned;
        n_drain     = r_drain;
        n_idx       = r_idx;
        n_last_idx  = r_last_idx;
        n_d_wired   = r_d_wired;
        n_d_arp     = r_d_arp;
        n_d_end     = r_d_end;
        o_req_valid = 1'b0;
        o_req       = '0;
        if (r_drain) begin
            if (!i_full) begin
                o_req_valid = 1'b1;
                o_req.pos   = POS_W'(r_idx);
                o_req.data  = r_hold[r_idx];
                o_req.wired = r_d_wired;
                o_req.arp   = r_d_arp;
                o_req.last  = r_d_end && (r_idx == r_last_idx);
                if (r_idx == r_last_idx) begin
                    n_drain = 1'b0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
        end else if (i_acc) begin
            n_drop = drop_base;
            n_arp  = arp_base;
            if (in_hdr) begin
                if (pos_base == POS_W'(HDR_LEN - 1)) begin
                    if (type_now == TYPE_IPV6) begin
                        n_drop = 1'b1;
                    end else begin
                        n_arp      = (type_now == TYPE_ARP);
                        n_drain    = 1'b1;
                        n_idx      = '0;
                        n_last_idx = IDX_W'(HDR_LEN - 1);
                        n_d_wired  = i_in_word.toward_wired;
                        n_d_arp    = (type_now == TYPE_ARP);
                        n_d_end    = i_in_word.frame_end;
                        if ((type_now == TYPE_ARP) && !i_in_word.toward_wired) begin
                            n_learned = {r_src[0], r_src[1], r_src[2],
                                         r_src[3], r_src[4], r_src[5]};
                        end
                    end
                end else if (i_in_word.frame_end) begin
                    n_drain    = 1'b1;
                    n_idx      = '0;
                    n_last_idx = hdr_idx;
                    n_d_wired  = i_in_word.toward_wired;
                    n_d_arp    = arp_base;
                    n_d_end    = 1'b1;
                end
            end else if (!drop_base) begin
                o_req_valid = 1'b1;
                o_req.pos   = pos_base;
                o_req.data  = i_in_word.frame_byte;
                o_req.wired = i_in_word.toward_wired;
                o_req.arp   = arp_base;
                o_req.last  = i_in_word.frame_end;
            end
            if (i_in_word.frame_end) begin
                n_pos  = '0;
                n_drop = 1'b0;
                n_arp  = 1'b0;
            end else if (pos_base < POS_W'(MAX_FRAME_BYTES)) begin
                n_pos = pos_base + 1'b1;
            end else begin
                n_pos = pos_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_drop    <= 1'b0;
            r_arp     <= 1'b0;
            r_learned <= '0;
            r_drain   <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_drop    <= n_drop;
            r_arp     <= n_arp;
            r_learned <= n_learned;
            r_drain   <= n_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_last_idx <= n_last_idx;
        r_d_wired  <= n_d_wired;
        r_d_arp    <= n_d_arp;
        r_d_end    <= n_d_end;
        if (i_acc && in_hdr) begin
            r_hold[hdr_idx] <= i_in_word.frame_byte;
        end
        if (i_acc && in_src) begin
            r_src[src_idx] <= i_in_word.frame_byte;
        end
    end

endmodule

FILE: hdl/fmrb_rewrite.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame MAC rewrite bridge byte rewrite and output stage
// Substitutes MAC bytes by position and direction, then holds the result in
// an output register backed by a skid register.
// ----------------------------------------------------------------------------
module fmrb_rewrite
    import fmrb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  t_byte_req   i_req,
    input  logic [47:0] i_station_mac,
    input  logic [47:0] i_learned_mac,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output t_out_word   o_out_word,
    output logic        o_full
);

    logic             r_main_valid, n_main_valid;
    logic             r_skid_valid, n_skid_valid;
    t_out_word        r_main, n_main;
    t_out_word        r_skid, n_skid;
    t_out_word        w_new;
    logic [POS_W-1:0] off_src, off_sha, off_tha;
    logic             take;

    assign off_src = i_req.pos - POS_W'(SRC_POS);
    assign off_sha = i_req.pos - POS_W'(ARP_SHA_POS);
    assign off_tha = i_req.pos - POS_W'(ARP_THA_POS);

    always_comb begin
        w_new.out_byte = i_req.data;
        w_new.out_last = i_req.last;
        if (!i_req.wired) begin
            if ((i_req.pos >= POS_W'(SRC_POS)) && (i_req.pos < POS_W'(SRC_POS + MAC_LEN))) begin
                w_new.out_byte = mac_byte(i_station_mac, off_src[MAC_IDX_W-1:0]);
            end else if (i_req.arp && (i_req.pos >= POS_W'(ARP_SHA_POS))
                         && (i_req.pos < POS_W'(ARP_SHA_POS + MAC_LEN))) begin
                w_new.out_byte = mac_byte(i_station_mac, off_sha[MAC_IDX_W-1:0]);
            end
        end else begin
            if (i_req.pos < POS_W'(MAC_LEN)) begin
                w_new.out_byte = mac_byte(i_learned_mac, i_req.pos[MAC_IDX_W-1:0]);
            end else if (i_req.arp && (i_req.pos >= POS_W'(ARP_THA_POS))
                         && (i_req.pos < POS_W'(ARP_THA_POS + MAC_LEN))) begin
                w_new.out_byte = mac_byte(i_learned_mac, off_tha[MAC_IDX_W-1:0]);
            end
        end
    end

    assign take = r_main_valid && !i_out_stall;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (take) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (take || !r_main_valid) begin
            n_main_valid = i_req_valid;
            n_main       = w_new;
        end else if (i_req_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_main_valid;
    assign o_out_word  = r_main;
    assign o_full      = r_skid_valid;

endmodule
